/* hdl/hjdh_pkg.sv */
`default_nettype none

package hjdh_pkg;

  localparam int MODE_W     = 2;
  localparam int KEY_W      = 31;
  localparam int OUTCOME_W  = 3;
  localparam int SLOT_W     = 10;

  // occupancy is kept as a generation tag next to each stored key
  localparam int EPOCH_W    = 8;

  // residues by reciprocal multiplication, one stage per cycle
  localparam int RECIP_W    = 32;
  localparam int HASH_STEPS = 3;

  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [KEY_W-1:0]     key_t;
  typedef logic [OUTCOME_W-1:0] outcome_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [EPOCH_W-1:0]   epoch_t;

  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_PROBE  = 2'd1;
  localparam mode_t MODE_CLEAR  = 2'd2;
  localparam mode_t MODE_NONE   = 2'd3;

  localparam outcome_t OUT_STORED  = 3'd0;
  localparam outcome_t OUT_FULL    = 3'd1;
  localparam outcome_t OUT_FOUND   = 3'd2;
  localparam outcome_t OUT_ABSENT  = 3'd3;
  localparam outcome_t OUT_CLEARED = 3'd4;

  typedef struct packed {
    outcome_t outcome;
    slot_t    slot;
  } result_t;

endpackage

`default_nettype wire

/* hdl/hjdh_ifs.sv */
`default_nettype none

interface hjdh_in_if import hjdh_pkg::*;;
  logic  valid;
  logic  ready;
  mode_t mode;
  key_t  key;

  modport source (output valid, output mode, output key, input ready);
  modport sink (input valid, input mode, input key, output ready);
endinterface

interface hjdh_out_if import hjdh_pkg::*;;
  logic     valid;
  logic     ready;
  outcome_t outcome;
  slot_t    slot;

  modport source (output valid, output outcome, output slot, input ready);
  modport sink (input valid, input outcome, input slot, output ready);
endinterface

`default_nettype wire

/* hdl/hash_join_double_hash_table.sv */
`default_nettype none

// channel   dir  payload              word
// items     in   mode[1:0] key[30:0]   one build, probe or clear request
// results   out  outcome[2:0] slot[9:0] one result per request
//
// insert/probe: accept, the residue steps, then the probe walk and the done state;
//   the probe walk reads the table memory at one slot per cycle
// clear: bumps the generation tag; every 255th clear wraps the tag and sweeps the table
// after reset a sweep over all TABLE_SIZE slots marks them free; items.ready is low meanwhile
// a result waits in the output register; the next request is taken while it waits, but its
//   own result is held until the output register is free

module hash_join_double_hash_table import hjdh_pkg::*; #(
  parameter int TABLE_SIZE = 1021
) (
  input  logic       clk,
  input  logic       rst,
  hjdh_in_if.sink    items,
  hjdh_out_if.source results
);

  localparam int SW  = $clog2(TABLE_SIZE);
  localparam int SW1 = SW + 1;
  localparam int CW  = $clog2(TABLE_SIZE + 1);
  localparam int PW  = (SW > SLOT_W) ? SW : SLOT_W;
  localparam int MW  = EPOCH_W + KEY_W;
  localparam int HSW = $clog2(HASH_STEPS);
  localparam int PRW = KEY_W + RECIP_W;

  localparam logic [SW:0]     N_EXT   = SW1'(TABLE_SIZE);
  localparam logic [SW:0]     N1_EXT  = SW1'(TABLE_SIZE - 1);
  localparam logic [SW-1:0]   LAST_IX = SW'(TABLE_SIZE - 1);
  localparam logic [CW-1:0]   LAST_PROBE = CW'(TABLE_SIZE - 1);
  localparam logic [HSW-1:0]  LAST_STEP  = HSW'(HASH_STEPS - 1);

  // floor(2^32 / m): the quotient estimate is exact or one short
  localparam logic [RECIP_W-1:0] RECIP_N  = RECIP_W'((64'd1 << RECIP_W) / 64'(TABLE_SIZE));
  localparam logic [RECIP_W-1:0] RECIP_N1 = RECIP_W'((64'd1 << RECIP_W) / 64'(TABLE_SIZE - 1));

  localparam logic [2:0] ST_SWEEP = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_PROBE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]         state;
  mode_t              mode_q;
  key_t               key_q;
  logic [HSW-1:0]     step;
  logic [SW:0]        q1;
  logic [SW:0]        q2;
  logic [SW:0]        d1;
  logic [SW:0]        d2;
  logic [SW-1:0]      pos;
  logic [SW-1:0]      stride;
  logic [SW-1:0]      rd_pos;
  logic               rd_valid;
  logic [CW-1:0]      cnt;
  epoch_t             epoch;
  logic [SW-1:0]      sweep_addr;
  logic               sweep_clear;
  result_t            res;
  logic               out_valid;
  result_t            out_res;

  // table memory: {generation tag, key}
  logic [MW-1:0] mem [TABLE_SIZE];
  logic [MW-1:0] rd_data;
  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;

  logic [PRW-1:0] prod1;
  logic [PRW-1:0] prod2;
  logic [SW:0]    diff1;
  logic [SW:0]    diff2;
  logic [SW-1:0]  r1_fix;
  logic [SW-1:0]  r2_fix;
  logic [SW:0]    pos_sum;
  logic [SW-1:0]  pos_next;
  logic           used;
  logic           hit;
  logic           evaluating;
  logic           stop;
  logic           exhausted;
  logic [PW-1:0]  rd_pos_ext;
  logic           out_free;

  assign items.ready     = (state == ST_IDLE);
  assign results.valid   = out_valid;
  assign results.outcome = out_res.outcome;
  assign results.slot    = out_res.slot;

  always_comb begin
    prod1      = {{RECIP_W{1'b0}}, key_q} * {{KEY_W{1'b0}}, RECIP_N};
    prod2      = {{RECIP_W{1'b0}}, key_q} * {{KEY_W{1'b0}}, RECIP_N1};
    // the remainder is below 2m, so the low bits carry it exactly
    diff1      = key_q[SW:0] - q1 * N_EXT;
    diff2      = key_q[SW:0] - q2 * N1_EXT;
    r1_fix     = (d1 >= N_EXT) ? SW'(d1 - N_EXT) : d1[SW-1:0];
    r2_fix     = (d2 >= N1_EXT) ? SW'(d2 - N1_EXT) : d2[SW-1:0];
    pos_sum    = {1'b0, pos} + {1'b0, stride};
    if (pos_sum >= N_EXT) begin
      pos_sum = pos_sum - N_EXT;
    end
    pos_next   = pos_sum[SW-1:0];
    used       = (rd_data[KEY_W +: EPOCH_W] == epoch);
    hit        = (rd_data[KEY_W-1:0] == key_q);
    evaluating = (state == ST_PROBE) && rd_valid;
    stop       = !used || ((mode_q == MODE_PROBE) && hit);
    exhausted  = (cnt == LAST_PROBE);
    rd_pos_ext = PW'(rd_pos);
    out_free   = !out_valid || results.ready;

    mem_we    = 1'b0;
    mem_waddr = rd_pos;
    mem_wdata = {epoch, key_q};
    if (state == ST_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_addr;
      mem_wdata = '0;
    end else if (evaluating && (mode_q == MODE_INSERT) && !used) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      sweep_addr  <= '0;
      sweep_clear <= 1'b0;
      epoch       <= EPOCH_W'(1);
      rd_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && results.ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_SWEEP: begin
          if (sweep_addr == LAST_IX) begin
            sweep_addr <= '0;
            epoch      <= EPOCH_W'(1);
            state      <= sweep_clear ? ST_DONE : ST_IDLE;
          end else begin
            sweep_addr <= sweep_addr + SW'(1);
          end
        end
        ST_IDLE: begin
          if (items.valid) begin
            mode_q <= items.mode;
            key_q  <= items.key;
            step   <= '0;
            unique case (items.mode) inside
              MODE_INSERT, MODE_PROBE: begin
                state <= ST_HASH;
              end
              MODE_CLEAR: begin
                res <= '{outcome: OUT_CLEARED, slot: '0};
                if (epoch == '1) begin
                  sweep_clear <= 1'b1;
                  state       <= ST_SWEEP;
                end else begin
                  epoch <= epoch + EPOCH_W'(1);
                  state <= ST_DONE;
                end
              end
              default: begin
                res   <= '{outcome: OUT_ABSENT, slot: '0};
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_HASH: begin
          // quotient estimate, raw remainder, final correction
          q1   <= SW1'(prod1 >> RECIP_W);
          q2   <= SW1'(prod2 >> RECIP_W);
          d1   <= diff1;
          d2   <= diff2;
          step <= step + HSW'(1);
          if (step == LAST_STEP) begin
            pos      <= r1_fix;
            stride   <= r2_fix + SW'(1);
            cnt      <= '0;
            rd_valid <= 1'b0;
            state    <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          // reads run one slot ahead of the compare; the table is unchanged during a walk
          pos    <= pos_next;
          rd_pos <= pos;
          if (evaluating) begin
            cnt <= cnt + CW'(1);
          end
          if (evaluating && (stop || exhausted)) begin
            rd_valid <= 1'b0;
            state    <= ST_DONE;
            if (stop) begin
              if (mode_q == MODE_INSERT) begin
                res <= '{outcome: OUT_STORED, slot: rd_pos_ext[SLOT_W-1:0]};
              end else if (used) begin
                res <= '{outcome: OUT_FOUND, slot: rd_pos_ext[SLOT_W-1:0]};
              end else begin
                res <= '{outcome: OUT_ABSENT, slot: '0};
              end
            end else begin
              res <= '{outcome: (mode_q == MODE_INSERT) ? OUT_FULL : OUT_ABSENT,
                       slot: '0};
            end
          end else begin
            rd_valid <= 1'b1;
          end
        end
        ST_DONE: begin
          sweep_clear <= 1'b0;
          if (out_free) begin
            out_res   <= res;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_write_only_insert: assert property (@(posedge clk) disable iff (rst)
    (mem_we && (state != ST_SWEEP)) |-> (mode_q == MODE_INSERT) && evaluating && !used)
    else $error("table written outside an insert hit on a free slot");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE) |-> (cnt < CW'(TABLE_SIZE)) && ({1'b0, pos} < N_EXT))
    else $error("probe walk out of range");

  a_epoch_live: assert property (@(posedge clk) disable iff (rst)
    (state != ST_SWEEP) |-> (epoch != '0))
    else $error("free-slot tag in use as live generation");

  a_no_accept_after_reset: assert property (@(posedge clk)
    rst |=> !items.ready)
    else $error("request taken before initial sweep");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result loaded outside done state");

endmodule

`default_nettype wire
